@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Every check is disabled while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/slcd_pkg.sv @@
package slcd_pkg;

	localparam logic [31:0] SYNC_PATTERN   = 32'h2442494E; // "$BIN"
	localparam logic [7:0]  CR_BYTE        = 8'h0D;
	localparam logic [7:0]  LF_BYTE        = 8'h0A;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd12;
	localparam logic [16:0] MAX_LEN_RESET  = 17'd4096;

	// byte offsets within a frame; zero means hunting
	localparam logic [16:0] POS_HUNT    = 17'd0;
	localparam logic [16:0] POS_TYPE_LO = 17'd4;
	localparam logic [16:0] POS_TYPE_HI = 17'd5;
	localparam logic [16:0] POS_LEN_LO  = 17'd6;
	localparam logic [16:0] POS_LEN_HI  = 17'd7;
	localparam logic [16:0] POS_DATA    = 17'd8;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_GOOD     = 2'd0,
		STATUS_BAD_SUM  = 2'd1,
		STATUS_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   pbyte;
		logic [15:0]  pindex;
		status_t      status;
		logic [15:0]  msg_type;
		logic [16:0]  frame_len;
	} result_t;

endpackage

@@ rtl/core/slcd_in_reg.sv @@
module slcd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	// hold the registered byte while the engine cannot take it
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

@@ rtl/core/slcd_engine.sv @@
`include "assert_macros.svh"

module slcd_engine import slcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [16:0] cfg_data,
	input  logic        valid_s1,
	input  logic [7:0]  byte_s1,
	input  logic        advance,
	output logic        res_valid,
	output result_t     res
);

	logic [16:0] max_len_q;
	logic [31:0] win_q, win_d;
	logic [16:0] pos_q, pos_d;
	logic [15:0] type_q, type_d;
	logic [16:0] len_q, len_d;
	logic [16:0] tpos_q, tpos_d;     // offset of first trailer byte
	logic [15:0] sum_q, sum_d;
	logic [15:0] tsum_q, tsum_d;
	logic        cr_q, cr_d;
	logic [31:0] win_shift;
	logic [16:0] len_calc;
	logic [16:0] tpos_calc;
	logic        take;

	assign take      = valid_s1 && advance;
	assign win_shift = {win_q[23:0], byte_s1};
	assign len_calc  = {1'b0, byte_s1, len_q[7:0]} + FRAME_OVERHEAD;
	assign tpos_calc = {1'b0, byte_s1, len_q[7:0]} + POS_DATA;

	always_comb begin
		win_d     = win_q;
		pos_d     = pos_q;
		type_d    = type_q;
		len_d     = len_q;
		tpos_d    = tpos_q;
		sum_d     = sum_q;
		tsum_d    = tsum_q;
		cr_d      = cr_q;
		res_valid = 1'b0;
		res.kind   = KIND_DATA;
		res.pbyte  = 8'h00;
		res.pindex = 16'h0000;
		res.status = STATUS_GOOD;

		if (pos_q == POS_HUNT) begin
			win_d = win_shift;
			if (win_shift == SYNC_PATTERN) begin
				pos_d  = POS_TYPE_LO;
				sum_d  = 16'h0000;
				tsum_d = 16'h0000;
				cr_d   = 1'b0;
			end
		end else if (pos_q < POS_DATA) begin
			pos_d = pos_q + 17'd1;
			case (pos_q)
				POS_TYPE_LO: type_d = {8'h00, byte_s1};
				POS_TYPE_HI: type_d = {byte_s1, type_q[7:0]};
				POS_LEN_LO:  len_d  = {9'd0, byte_s1};
				default: begin
					len_d  = len_calc;
					tpos_d = tpos_calc;
					if (len_calc > max_len_q) begin
						pos_d      = POS_HUNT;
						res_valid  = 1'b1;
						res.kind   = KIND_VERDICT;
						res.status = STATUS_TOO_LONG;
					end
				end
			endcase
		end else if (pos_q < tpos_q) begin
			sum_d      = sum_q + {8'h00, byte_s1};
			pos_d      = pos_q + 17'd1;
			res_valid  = 1'b1;
			res.kind   = KIND_DATA;
			res.pbyte  = byte_s1;
			res.pindex = 16'(pos_q - POS_DATA);
		end else if (pos_q == tpos_q) begin
			tsum_d = {8'h00, byte_s1};
			pos_d  = pos_q + 17'd1;
		end else if (pos_q == tpos_q + 17'd1) begin
			tsum_d = {byte_s1, tsum_q[7:0]};
			pos_d  = pos_q + 17'd1;
		end else if (pos_q == tpos_q + 17'd2) begin
			cr_d  = (byte_s1 == CR_BYTE);
			pos_d = pos_q + 17'd1;
		end else begin
			pos_d      = POS_HUNT;
			res_valid  = 1'b1;
			res.kind   = KIND_VERDICT;
			res.status = ((sum_q == tsum_q) && cr_q && (byte_s1 == LF_BYTE)) ?
				STATUS_GOOD : STATUS_BAD_SUM;
		end

		// type and length as they stand after this byte
		res.msg_type  = type_d;
		res.frame_len = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
			win_q     <= 32'h0000_0000;
			pos_q     <= POS_HUNT;
			type_q    <= 16'h0000;
			len_q     <= 17'd0;
			tpos_q    <= 17'd0;
			sum_q     <= 16'h0000;
			tsum_q    <= 16'h0000;
			cr_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (take) begin
				win_q  <= win_d;
				pos_q  <= pos_d;
				type_q <= type_d;
				len_q  <= len_d;
				tpos_q <= tpos_d;
				sum_q  <= sum_d;
				tsum_q <= tsum_d;
				cr_q   <= cr_d;
			end
		end
	end

	// offsets 1..3 are never reached: sync jumps straight to the type field
	`ASSERT_ALWAYS(a_pos_no_gap, clk, arst_n, (pos_q == POS_HUNT) || (pos_q >= POS_TYPE_LO))
	// inside a frame the position never runs past the LF byte
	`ASSERT_IMPLY(a_pos_bound, clk, arst_n, pos_q >= POS_DATA, pos_q <= tpos_q + 17'd3)
	// trailer offset stays tied to the total length
	`ASSERT_IMPLY(a_tpos_len, clk, arst_n, pos_q >= POS_DATA, len_q == tpos_q + 17'd4)

endmodule

@@ rtl/core/slcd_out_reg.sv @@
module slcd_out_reg import slcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  logic    res_valid,
	input  result_t res,
	input  logic    out_stall,
	output logic    advance,
	output logic    out_valid,
	output result_t res_q
);

	// the result register is free when empty or being drained this cycle
	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/core/sync_length_checksum_deframer.sv @@
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_stall    rx_byte
// out       out  out_valid/out_stall  out_kind, payload_byte, payload_index,
//                                     frame_status, msg_type, frame_len
// cfg       in   cfg_valid/cfg_ready  cfg_data (max_frame_len)
//
// One byte per cycle sustained while the receiver does not stall; every input
// byte takes one transfer slot. An input transfer reaches the result through the
// input register, then the frame engine writes the result register.
// Reset clears max_frame_len to 4096 and returns the engine to sync hunting.
// An output stall holds the result register; in_stall is high whenever the
// input register holds a byte while the result register is full and stalled,
// so no byte is lost or doubled.

`include "assert_macros.svh"

module sync_length_checksum_deframer import slcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	// received byte stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,

	// data bytes and end-of-frame verdicts
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [1:0]  frame_status,
	output logic [15:0] msg_type,
	output logic [16:0] frame_len,

	// max_frame_len write channel, always ready
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;     // result register can take the engine's output
	logic       res_valid;
	result_t    res;
	result_t    res_q;

	assign cfg_ready = 1'b1;

	slcd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// sync hunt, header capture with length limit check, data sum and trailer check
	slcd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	slcd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.advance   (advance),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign out_kind      = logic'(res_q.kind);
	assign payload_byte  = res_q.pbyte;
	assign payload_index = res_q.pindex;
	assign frame_status  = 2'(res_q.status);
	assign msg_type      = res_q.msg_type;
	assign frame_len     = res_q.frame_len;

	// any reported frame carries at least the fixed overhead
	`ASSERT_IMPLY(a_len_floor, clk, arst_n, out_valid, frame_len >= FRAME_OVERHEAD)
	// data transfers never carry a failure status
	`ASSERT_IMPLY(a_data_status, clk, arst_n, out_valid && (out_kind == KIND_DATA), frame_status == STATUS_GOOD)
	// input is only held back while the result register is blocked
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

@@ tb/slcd_checker.sv @@
`timescale 1ns / 100ps

module slcd_checker import slcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        out_kind,
	input  logic [7:0]  payload_byte,
	input  logic [15:0] payload_index,
	input  logic [1:0]  frame_status,
	input  logic [15:0] msg_type,
	input  logic [16:0] frame_len,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [16:0] cfg_data,
	output int          errors,
	output int          pending
);

	// deframer state as the block should hold it
	logic [16:0] max_len;
	logic [31:0] window;
	logic [16:0] pos;
	logic [15:0] type_q;
	logic [16:0] len_q;
	logic [15:0] data_sum;
	logic [15:0] trailer;
	logic        cr_ok;

	result_t due_results[$];

	// advance the frame state by one byte; returns 1 when the byte yields a result
	function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
		r = '0;
		r.kind = KIND_VERDICT;
		r.status = STATUS_GOOD;
		if (pos == POS_HUNT) begin
			window = {window[23:0], b};
			if (window == SYNC_PATTERN) begin
				pos = POS_TYPE_LO;
				data_sum = '0;
				trailer = '0;
				cr_ok = 1'b0;
			end
			return 1'b0;
		end
		if (pos < POS_DATA) begin
			case (pos)
				POS_TYPE_LO: type_q = {8'h00, b};
				POS_TYPE_HI: type_q[15:8] = b;
				POS_LEN_LO:  len_q = {9'd0, b};
				default: begin
					len_q = {1'b0, b, len_q[7:0]} + FRAME_OVERHEAD;
					if (len_q > max_len) begin
						pos = POS_HUNT;
						r.status = STATUS_TOO_LONG;
						r.msg_type = type_q;
						r.frame_len = len_q;
						return 1'b1;
					end
				end
			endcase
			pos = pos + 17'd1;
			return 1'b0;
		end
		r.msg_type = type_q;
		r.frame_len = len_q;
		if (pos < len_q - 17'd4) begin
			data_sum = data_sum + 16'(b);
			r.kind = KIND_DATA;
			r.pbyte = b;
			r.pindex = 16'(pos - POS_DATA);
			pos = pos + 17'd1;
			return 1'b1;
		end
		if (pos == len_q - 17'd4) begin
			trailer = {8'h00, b};
		end else if (pos == len_q - 17'd3) begin
			trailer[15:8] = b;
		end else if (pos == len_q - 17'd2) begin
			cr_ok = (b == CR_BYTE);
		end else begin
			// LF slot closes the frame
			pos = POS_HUNT;
			if (!(data_sum == trailer && cr_ok && b == LF_BYTE))
				r.status = STATUS_BAD_SUM;
			return 1'b1;
		end
		pos = pos + 17'd1;
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t due;
		result_t fresh;
		if (!arst_n) begin
			max_len = MAX_LEN_RESET;
			window = '0;
			pos = POS_HUNT;
			type_q = '0;
			len_q = '0;
			data_sum = '0;
			trailer = '0;
			cr_ok = 1'b0;
			due_results.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				max_len = cfg_data;
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, got kind %0d byte %h index %0d",
						$time, out_kind, payload_byte, payload_index);
					$display("%0t:   status %0d type %h len %0d",
						$time, frame_status, msg_type, frame_len);
				end else begin
					due = due_results.pop_front();
					check_field("out_kind", 17'(due.kind), 17'(out_kind));
					check_field("payload_byte", 17'(due.pbyte), 17'(payload_byte));
					check_field("payload_index", 17'(due.pindex), 17'(payload_index));
					check_field("frame_status", 17'(due.status), 17'(frame_status));
					check_field("msg_type", 17'(due.msg_type), 17'(msg_type));
					check_field("frame_len", due.frame_len, frame_len);
				end
			end
			if (in_valid && !in_stall) begin
				if (deframe_byte(rx_byte, fresh))
					due_results.push_back(fresh);
			end
		end
		pending = due_results.size();
	end

endmodule

@@ tb/sync_length_checksum_deframer_tb.sv @@
`timescale 1ns / 100ps

module sync_length_checksum_deframer_tb import slcd_pkg::*; ();

	// generous bound for the watchdog below
	localparam int CYCLE_LIMIT = 1000000;
	// leave margin for the input and result registers to empty before touching config
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_LEN_TOP = 65547;
	// framed bytes each random phase must reach, three phases in all
	localparam int RANDOM_BYTES = 390;

	// ways a generated frame can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_CR,
		FLAW_LF,
		FLAW_CUT
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        out_kind;
	logic [7:0]  payload_byte;
	logic [15:0] payload_index;
	logic [1:0]  frame_status;
	logic [15:0] msg_type;
	logic [16:0] frame_len;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;

	int errors;
	int pending;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int cur_max = int'(MAX_LEN_RESET); // our copy of max_frame_len, steers frame sizes
	int framed_bytes = 0;          // bytes sent as part of frames in this phase

	sync_length_checksum_deframer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_kind      (out_kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_status  (frame_status),
		.msg_type      (msg_type),
		.frame_len     (frame_len),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	slcd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_kind      (out_kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_status  (frame_status),
		.msg_type      (msg_type),
		.frame_len     (frame_len),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	initial forever #5 clk = ~clk;

	// watchdog: a hung handshake or a lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** sync_length_checksum_deframer: FAILED **");
			$finish;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(99) < rx_stall_pct);

	// One byte transfer. Random idle cycles go in front; once valid is up it
	// stays up with the same byte until the edge where stall is low.
	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Hold off the sender until every predicted result has come out, then let
	// the pipeline empty of bytes that produce nothing (header, trailer).
	// The first edge lets the checker book the last transfer before we look.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// max_frame_len write, only ever with the block idle
	task automatic set_max_len(input int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= 17'(v);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_max = v;
	endtask

	function automatic logic [7:0] wrong_byte(input logic [7:0] good);
		logic [7:0] b;
		b = 8'($urandom);
		return (b == good) ? ~good : b;
	endfunction

	task automatic send_noise(input int n);
		repeat (n) push_byte(8'($urandom));
	endtask

	// "$B" or "$BI" just ahead of a real sync word
	task automatic send_partial_sync(input bit three);
		push_byte(SYNC_PATTERN[31:24]);
		push_byte(SYNC_PATTERN[23:16]);
		if (three)
			push_byte(SYNC_PATTERN[15:8]);
	endtask

	// Build one frame and send it. fill < 0 gives random data, else a constant.
	// A frame over the current limit stops after the length field, as the
	// block drops back to hunting there.
	task automatic send_frame(input logic [15:0] msg, input logic [15:0] len_field,
			input int fill, input flaw_t flaw);
		logic [7:0]  seq[$];
		logic [15:0] sum;
		logic [7:0]  b;
		int          total;
		seq = '{SYNC_PATTERN[31:24], SYNC_PATTERN[23:16], SYNC_PATTERN[15:8],
			SYNC_PATTERN[7:0], msg[7:0], msg[15:8], len_field[7:0], len_field[15:8]};
		total = int'(len_field) + int'(FRAME_OVERHEAD);
		sum = '0;
		if (total <= cur_max) begin
			repeat (len_field) begin
				b = (fill < 0) ? 8'($urandom) : 8'(fill);
				seq.push_back(b);
				sum = sum + 16'(b);
			end
			if (flaw == FLAW_SUM)
				sum = sum + 16'($urandom_range(65535, 1));
			seq.push_back(sum[7:0]);
			seq.push_back(sum[15:8]);
			seq.push_back(flaw == FLAW_CR ? wrong_byte(CR_BYTE) : CR_BYTE);
			seq.push_back(flaw == FLAW_LF ? wrong_byte(LF_BYTE) : LF_BYTE);
			// truncated frame: whatever follows is swallowed as its tail
			if (flaw == FLAW_CUT)
				repeat ($urandom_range(seq.size() - 1, 1)) void'(seq.pop_back());
		end
		foreach (seq[i])
			push_byte(seq[i]);
		framed_bytes += seq.size();
	endtask

	// Mostly well-formed frames with random content and short data regions;
	// some damaged, cut or oversized ones, some line noise in between.
	task automatic random_frame();
		int          r;
		int          cap;
		int          roof;
		flaw_t       flaw;
		logic [15:0] len_field;
		// now and then the sender waits for the output side to catch up
		if ($urandom_range(99) < 3)
			drain();
		r = $urandom_range(99);
		if (r < 20)
			send_noise($urandom_range(4, 1));
		else if (r < 30)
			send_partial_sync(1'($urandom_range(1)));
		r = $urandom_range(99);
		if (r < 70)
			flaw = FLAW_NONE;
		else if (r < 78)
			flaw = FLAW_SUM;
		else if (r < 84)
			flaw = FLAW_CR;
		else if (r < 90)
			flaw = FLAW_LF;
		else if (r < 96)
			flaw = FLAW_CUT;
		else
			flaw = FLAW_NONE;
		roof = cur_max - int'(FRAME_OVERHEAD);
		r = $urandom_range(99);
		if (r < 8 && cur_max < MAX_LEN_TOP) begin
			len_field = 16'($urandom_range(65535, cur_max - 11));
		end else begin
			cap = (r < 80) ? 24 : (r < 97) ? 300 : 1000;
			len_field = 16'($urandom_range(cap < roof ? cap : roof, 0));
		end
		send_frame(16'($urandom), len_field, -1, flaw);
	endtask

	task automatic random_phase();
		framed_bytes = 0;
		while (framed_bytes < RANDOM_BYTES)
			random_frame();
	endtask

	initial begin
		tx_idle_pct = 21;
		rx_stall_pct = 67;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset limit of 4096
		send_partial_sync(1'b1);
		send_frame(16'h0000, 16'd0, -1, FLAW_NONE);      // empty data region
		send_frame(16'hFFFF, 16'd3, 8'h00, FLAW_NONE);
		send_frame(16'hA55A, 16'd300, 8'hFF, FLAW_NONE); // sum wraps past 16 bits
		send_frame(16'h0001, 16'd5, -1, FLAW_SUM);
		send_frame(16'h0002, 16'd5, -1, FLAW_CR);
		send_frame(16'h0003, 16'd5, -1, FLAW_LF);
		send_noise(3);
		send_frame(16'h1234, 16'd4085, -1, FLAW_NONE);   // one byte over the limit
		send_frame(16'h4321, 16'hFFFF, -1, FLAW_NONE);   // largest length field
		send_frame(16'h8000, 16'd64, -1, FLAW_NONE);     // well inside the limit
		send_frame(16'h0055, 16'd10, -1, FLAW_CUT);
		send_frame(16'h00AA, 16'd2, -1, FLAW_NONE);

		// smallest limit: only an empty frame fits
		set_max_len(12);
		send_frame(16'h0F0F, 16'd0, -1, FLAW_NONE);
		send_frame(16'hF0F0, 16'd1, -1, FLAW_NONE);
		send_frame(16'h0F0F, 16'd0, -1, FLAW_SUM);

		// limit boundary at 40
		set_max_len(40);
		send_frame(16'h7777, 16'd28, -1, FLAW_NONE);
		send_frame(16'h8888, 16'd29, -1, FLAW_NONE);

		// random, sender idles a little, receiver a lot, tight limit
		set_max_len($urandom_range(300, 12));
		random_phase();

		// random, roles swapped, largest limit
		drain();
		tx_idle_pct = 67;
		rx_stall_pct = 21;
		set_max_len(MAX_LEN_TOP);
		random_phase();

		// full rate, random traffic under a mid-size limit
		drain();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		set_max_len($urandom_range(4096, 100));
		random_phase();

		drain();
		if (errors == 0 && pending == 0)
			$display("** sync_length_checksum_deframer: PASSED **");
		else
			$display("** sync_length_checksum_deframer: FAILED **");
		$finish;
	end

endmodule
